### rtl/fifo_queue_with_delete_top_macros.svh
// Assertion macros shared by the queue checker.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef FIFO_QUEUE_WITH_DELETE_TOP_MACROS_SVH
`define FIFO_QUEUE_WITH_DELETE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FQD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FQD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/fqd_pkg.sv
// Shared constants, opcode codes and the cell control struct for the queue.
// No dependencies.
package fqd_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_W     = 32;
  localparam int ITEM_W      = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_DELETE  = 2'd2,
    OP_LENGTH  = 2'd3
  } op_t;

  // Broadcast from the top level to every cell in the same cycle.
  typedef struct packed {
    logic               enq_en;
    logic               deq_en;
    logic               del_en;
    logic [CNT_W-1:0]   count;
    logic [VALUE_W-1:0] val;
  } cell_ctrl_t;

endpackage

### rtl/fifo_queue_with_delete_top.sv
// Top level of the FIFO queue with delete-by-value: decode, count and result register.
// Depends on fqd_pkg and fqd_cell.
//
//  channel | ports                                         | driven stall by
//  --------+-----------------------------------------------+----------------
//  in      | in_valid, in_stall, in_opcode, in_item_value  | this block
//  out     | out_valid, out_stall, out_status, out_value,  | downstream
//          | out_entry_count                               |
//
// One beat in, one beat out; each item finishes in the cycle it is accepted and
// its result appears on the out registers the next cycle. The speed is set by
// the cell row: every slot compares and shifts in parallel, with the first-match
// flag rippling from head to tail. Reset (rst_n low, synchronous) empties the
// queue and drops any pending result. While a result waits under out_stall the
// input is stalled; once it is taken a new beat can enter in the same cycle.
module fifo_queue_with_delete_top
  import fqd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_opcode,
  input  logic [ITEM_W-1:0]      in_item_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_status,
  output logic [ITEM_W-1:0]      out_value,
  output logic [COUNT_OUT_W-1:0] out_entry_count
);

  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic                   status_r;
  logic                   status_nxt;
  logic [ITEM_W-1:0]      value_r;
  logic [ITEM_W-1:0]      value_nxt;
  logic [COUNT_OUT_W-1:0] entry_count_r;

  logic                   accept;
  op_t                    op;
  logic [VALUE_W-1:0]     val;
  logic                   is_null;
  logic                   full;
  logic                   empty;
  logic                   found;
  cell_ctrl_t             ctrl;

  logic [VALUE_W-1:0]     cell_val [DEPTH];
  logic [DEPTH:0]         hit;

  // Hold the input while a finished result still waits downstream.
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign op      = op_t'(in_opcode);
  assign val     = in_item_value[VALUE_W-1:0];
  assign is_null = (val == '0);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);

  // Enables drive the cells and the count update; a rejected request leaves every slot alone.
  always_comb begin
    ctrl.enq_en = accept && (op == OP_ENQUEUE) && !is_null && !full;
    ctrl.deq_en = accept && (op == OP_DEQUEUE) && !empty;
    ctrl.del_en = accept && (op == OP_DELETE) && !is_null;
    ctrl.count  = count_r;
    ctrl.val    = val;
  end

  // Row of slots, head at index 0; each takes its neighbor's value on a shift.
  assign hit[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_W-1:0] nbr;
    if (i == DEPTH - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_val[i+1];
    end

    fqd_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cell_idx  (CNT_W'(i)),
      .nbr_value (nbr),
      .hit_in    (hit[i]),
      .value     (cell_val[i]),
      .hit_out   (hit[i+1])
    );
  end

  assign found = hit[DEPTH];

  // Advance the count and form the result of the beat.
  always_comb begin
    count_nxt  = count_r;
    status_nxt = 1'b0;
    value_nxt  = '0;
    case (op)
      OP_ENQUEUE: begin
        status_nxt = is_null | full;
        if (ctrl.enq_en) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DEQUEUE: begin
        status_nxt = empty;
        if (ctrl.deq_en) begin
          count_nxt = count_r - CNT_W'(1);
          value_nxt = ITEM_W'(cell_val[0]);
        end
      end
      OP_DELETE: begin
        status_nxt = is_null | ~found;
        if (ctrl.del_en && found) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_LENGTH: begin
        status_nxt = 1'b0;
      end
      default: begin
        status_nxt = 1'b1;
      end
    endcase
  end

  // Result valid: set on accept, drop once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Payload registers load only on an accepted beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r      <= status_nxt;
      value_r       <= value_nxt;
      entry_count_r <= COUNT_OUT_W'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_value       = value_r;
  assign out_entry_count = entry_count_r;

endmodule

### rtl/fqd_cell.sv
// One queue slot: holds a value, compares it for delete, shifts from its neighbor.
// Depends on fqd_pkg.
module fqd_cell
  import fqd_pkg::*;
(
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic [CNT_W-1:0]   cell_idx,
  input  logic [VALUE_W-1:0] nbr_value,
  input  logic               hit_in,
  output logic [VALUE_W-1:0] value,
  output logic               hit_out
);

  logic [VALUE_W-1:0] value_r;
  logic [VALUE_W-1:0] value_nxt;
  logic               live;
  logic               match;
  logic               shift;
  logic               write;

  assign live    = cell_idx < ctrl.count;
  assign match   = live && (value_r == ctrl.val);
  assign hit_out = hit_in | match;

  // Shift toward the head on dequeue, or at and after the first delete match.
  assign shift = ctrl.deq_en || (ctrl.del_en && hit_out);
  assign write = ctrl.enq_en && (cell_idx == ctrl.count);

  always_comb begin
    value_nxt = value_r;
    if (write) begin
      value_nxt = ctrl.val;
    end else if (shift) begin
      value_nxt = nbr_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

### rtl/fqd_checker.sv
// Port-level checker for the queue top level, bound in below.
// Depends on fqd_pkg and fifo_queue_with_delete_top_macros.svh.
`include "fifo_queue_with_delete_top_macros.svh"

module fqd_checker
  import fqd_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic                   out_status,
  input logic [ITEM_W-1:0]      out_value,
  input logic [COUNT_OUT_W-1:0] out_entry_count
);

  // A stalled result holds its beat.
  `FQD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_value) && $stable(out_status) && $stable(out_entry_count), "stalled result changed")

  // The input stalls only behind a waiting result.
  `FQD_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with no result waiting")

  // An error never carries a value, and the count never passes the depth.
  `FQD_ASSERT_NOW(a_err_value, out_valid && out_status, out_value == '0, "error result with nonzero value")
  `FQD_ASSERT_NOW(a_count_max, out_valid, out_entry_count <= COUNT_OUT_W'(DEPTH), "count above depth")

endmodule

bind fifo_queue_with_delete_top fqd_checker u_fqd_checker (.*);

### verif/tb_fifo_queue_with_delete_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for fifo_queue_with_delete_top: a queue-based predictor,
// a directed opening, random fill/drain traffic, random input gaps and random output stalls.
// Depends on fqd_pkg and the RTL of fifo_queue_with_delete_top.
module tb_fifo_queue_with_delete_top;
  import fqd_pkg::*;

  // Result status codes on out_status.
  localparam logic RES_OK  = 1'b0;
  localparam logic RES_ERR = 1'b1;

  // No beat on either channel for this many cycles ends the run as a failure.
  // The longest legal quiet stretch is the receiver hold-off below.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  // Start the hold-off once this many beats have gone in.
  localparam int HOLD_AFTER     = 200;
  // Open no new idle gaps once at most this many beats remain to be sent.
  localparam int CALM_TAIL      = 150;
  localparam int RANDOM_BLOCKS  = 14;
  localparam int BLOCK_BEATS    = 100;

  typedef struct {
    op_t               op;
    logic [ITEM_W-1:0] val;
  } cmd_beat_t;

  typedef struct packed {
    logic                   status;
    logic [ITEM_W-1:0]      value;
    logic [COUNT_OUT_W-1:0] count;
  } queue_result_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             in_opcode;
  logic [ITEM_W-1:0]      in_item_value;
  logic                   out_valid;
  logic                   out_stall;
  logic                   out_status;
  logic [ITEM_W-1:0]      out_value;
  logic [COUNT_OUT_W-1:0] out_entry_count;

  fifo_queue_with_delete_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_item_value  (in_item_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_value      (out_value),
    .out_entry_count(out_entry_count)
  );

  // Commands waiting to be driven, filled once before reset is released.
  cmd_beat_t          cmd_backlog[$];
  // Shadow of the queue contents, head at index 0.
  logic [VALUE_W-1:0] held_vals[$];
  // Results predicted but not yet seen on the out channel, oldest first.
  queue_result_t      due_results[$];
  // Values recently enqueued by the generator, so deletes often find a match.
  logic [ITEM_W-1:0]  recent_enq[$];

  int  total_beats;
  int  beats_in;
  int  beats_out;
  int  err_count;
  int  quiet_cycles;
  int  send_gap;
  int  drain_gap;
  bit  in_took;
  bit  hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction: apply one command to the shadow queue and return its result.
  // ---------------------------------------------------------------------------
  function automatic queue_result_t predict_result(op_t op, logic [ITEM_W-1:0] raw);
    queue_result_t      res;
    logic [VALUE_W-1:0] v;
    int                 hit;
    v          = raw[VALUE_W-1:0];
    res.status = RES_OK;
    res.value  = '0;
    hit        = -1;
    case (op)
      OP_ENQUEUE: begin
        // Reject the null value and any enqueue into a full queue.
        if (v == '0 || held_vals.size() >= DEPTH) begin
          res.status = RES_ERR;
        end else begin
          held_vals.push_back(v);
        end
      end
      OP_DEQUEUE: begin
        if (held_vals.size() == 0) begin
          res.status = RES_ERR;
        end else begin
          res.value = held_vals.pop_front();
        end
      end
      OP_DELETE: begin
        // Remove the first match from the head; later entries close up behind it.
        if (v == '0) begin
          res.status = RES_ERR;
        end else begin
          foreach (held_vals[k]) begin
            if (hit < 0 && held_vals[k] == v) hit = k;
          end
          if (hit < 0) begin
            res.status = RES_ERR;
          end else begin
            held_vals.delete(hit);
          end
        end
      end
      default: ;  // length query leaves the queue alone
    endcase
    res.count = COUNT_OUT_W'(held_vals.size());
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_count++;
    $display("%0t mismatch on %s: got %0h, expected %0h (result beat %0d)",
             $time, what, got, want, beats_out);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  task automatic add_beat(op_t op, logic [ITEM_W-1:0] val);
    cmd_beat_t b;
    b.op  = op;
    b.val = val;
    cmd_backlog.push_back(b);
    if (op == OP_ENQUEUE && val != '0) begin
      recent_enq.push_back(val);
      if (recent_enq.size() > 32) void'(recent_enq.pop_front());
    end
  endtask

  // Mostly a small pool so duplicates and matches are common; some wide values
  // to toggle every bit; an occasional null.
  function automatic logic [ITEM_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r <= 4) return $urandom();
    return $urandom_range(1, 12);
  endfunction

  task automatic add_random_beat(traffic_mix_t mix);
    int                enq_pct;
    int                deq_pct;
    int                del_pct;
    int                r;
    logic [ITEM_W-1:0] v;
    case (mix)
      MIX_FILL:  begin enq_pct = 55; deq_pct = 15; del_pct = 20; end
      MIX_DRAIN: begin enq_pct = 15; deq_pct = 45; del_pct = 30; end
      default:   begin enq_pct = 35; deq_pct = 25; del_pct = 30; end
    endcase
    r = $urandom_range(0, 99);
    if (r < enq_pct) begin
      add_beat(OP_ENQUEUE, pick_value());
    end else if (r < enq_pct + deq_pct) begin
      add_beat(OP_DEQUEUE, $urandom());
    end else if (r < enq_pct + deq_pct + del_pct) begin
      // Aim half the deletes at something that was recently put in.
      if (recent_enq.size() > 0 && $urandom_range(0, 1) == 1) begin
        v = recent_enq[$urandom_range(0, recent_enq.size() - 1)];
      end else begin
        v = pick_value();
      end
      add_beat(OP_DELETE, v);
    end else begin
      add_beat(OP_LENGTH, $urandom());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: build stimulus, reset, wait for everything to drain.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = OP_LENGTH;
    in_item_value = '0;
    out_stall     = 1'b0;
    hold_req      = 1'b0;
    beats_in      = 0;
    beats_out     = 0;
    err_count     = 0;
    quiet_cycles  = 0;
    send_gap      = 0;
    drain_gap     = 0;

    // Directed opening: empty-queue errors, nulls, a lone entry deleted to
    // empty, then fill to the brim, overflow, delete the first of duplicates.
    add_beat(OP_DEQUEUE, 32'hDEAD_BEEF);
    add_beat(OP_DELETE,  32'h0000_0005);
    add_beat(OP_LENGTH,  32'hFFFF_FFFF);
    add_beat(OP_ENQUEUE, 32'h0000_0000);
    add_beat(OP_DELETE,  32'h0000_0000);
    add_beat(OP_ENQUEUE, 32'hFFFF_FFFF);
    add_beat(OP_DELETE,  32'hFFFF_FFFF);
    add_beat(OP_LENGTH,  32'h0000_0000);
    for (int k = 0; k < DEPTH; k++) begin
      case (k)
        0:       add_beat(OP_ENQUEUE, 32'hFFFF_FFFF);
        1:       add_beat(OP_ENQUEUE, 32'h0000_0001);
        2:       add_beat(OP_ENQUEUE, 32'h8000_0000);
        3:       add_beat(OP_ENQUEUE, 32'h5A5A_A5A5);
        default: add_beat(OP_ENQUEUE, (k % 3) + 2);
      endcase
    end
    add_beat(OP_ENQUEUE, 32'h0000_0007);
    add_beat(OP_DELETE,  32'h0000_0003);
    add_beat(OP_DEQUEUE, 32'h0000_0000);
    add_beat(OP_LENGTH,  32'h1234_5678);

    // Random traffic in blocks that lean toward filling, draining or neither.
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      traffic_mix_t mix;
      case ($urandom_range(0, 2))
        0:       mix = MIX_FILL;
        1:       mix = MIX_DRAIN;
        default: mix = MIX_EVEN;
      endcase
      for (int k = 0; k < BLOCK_BEATS; k++) add_random_beat(mix);
    end
    total_beats = cmd_backlog.size();

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    wait (beats_in == total_beats);
    wait (due_results.size() == 0);
    // Give any stray result a chance to show up before the end.
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_fifo_queue_with_delete_top: clean");
    end else begin
      $display("tb_fifo_queue_with_delete_top: errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: present the next command at the falling edge once the previous
  // beat was taken; hold the payload while stalled. Insert random gaps except
  // in the calm tail of the run.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (cmd_backlog.size() == 0) begin
        in_valid <= 1'b0;
      end else if (cmd_backlog.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
        // Open a sender gap, this cycle included; send_gap counts down the rest.
        send_gap = $urandom_range(1, 17) - 1;
        in_valid <= 1'b0;
      end else begin
        cmd_beat_t nxt;
        nxt = cmd_backlog.pop_front();
        in_valid      <= 1'b1;
        in_opcode     <= nxt.op;
        in_item_value <= nxt.val;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus the long hold-off when requested.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (drain_gap > 0) begin
      drain_gap--;
    end else if (cmd_backlog.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
      drain_gap = $urandom_range(1, 17);
    end
    out_stall <= hold_req || (drain_gap > 0);
  end

  // Long hold-off: stall the result channel while the sender keeps offering,
  // so the block backs up and stalls its input.
  initial begin
    wait (beats_in >= HOLD_AFTER);
    @(posedge clk);
    hold_req = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_req = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: at the rising edge, check any result beat against the oldest
  // prediction, then predict for any command beat. Watch for a hang.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    queue_result_t want;
    bit            out_took;
    in_took  = rst_n && in_valid && !in_stall;
    out_took = rst_n && out_valid && !out_stall;

    if (out_took) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with nothing expected", 64'(out_value), '0);
      end else begin
        want = due_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", 64'(out_status), 64'(want.status));
        if (out_value !== want.value)
          report_mismatch("value", 64'(out_value), 64'(want.value));
        if (out_entry_count !== want.count)
          report_mismatch("entry count", 64'(out_entry_count), 64'(want.count));
      end
      beats_out++;
    end

    if (in_took) begin
      due_results.push_back(predict_result(op_t'(in_opcode), in_item_value));
      beats_in++;
    end

    if (rst_n) begin
      if (in_took || out_took) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no beat for %0d cycles, %0d results outstanding",
                 quiet_cycles, due_results.size());
        $display("tb_fifo_queue_with_delete_top: errors");
        $finish;
      end
    end
  end

endmodule
